// ----- design/bitlen_pkg.sv -----
package bitlen_pkg;

  localparam logic [26:0] MaxCount = 27'd100000000;
  localparam int unsigned MaxRes = 32;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_MIN    = 4'd1,
    PH_MAX    = 4'd2,
    PH_FIXED  = 4'd3,
    PH_MEAN   = 4'd4,
    PH_SIZES  = 4'd5,
    PH_DELTA  = 4'd6,
    PH_RUNLEN = 4'd7,
    PH_RUN    = 4'd8,
    PH_SKIP   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WIDTH = 2'd1,
    ST_EARLY = 2'd2
  } status_e;

  // decode engine sequencing
  typedef enum logic [1:0] {
    EN_IDLE = 2'd0,
    EN_RUN  = 2'd1,
    EN_FAIL = 2'd2
  } eng_e;

  // one request from the front to the decode engine
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } word_req_t;

  // one run-length coded result
  typedef struct packed {
    logic [31:0] value;
    logic [26:0] rep;
    logic        last;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] sext32(logic [31:0] v, logic [5:0] n);
    logic [31:0] m;
    logic [31:0] r;
    m = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
    r = v & m;
    if (n == 6'd0) begin
      r = 32'd0;
    end else if (n < 6'd32 && v[n[4:0] - 5'd1]) begin
      r = r | ~m;
    end
    return r;
  endfunction

endpackage

// ----- design/bitlen_fifo.sv -----
module bitlen_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bitlen_pkg::word_req_t   data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output bitlen_pkg::word_req_t   data_o,
  output logic                    empty_o
);

  bitlen_pkg::word_req_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

endmodule

// ----- design/bitlen_engine.sv -----
module bitlen_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [26:0]           count_i,
  input  logic                  req_valid_i,
  input  bitlen_pkg::word_req_t req_i,
  output logic                  req_take_o,
  output logic                  res_valid_o,
  output bitlen_pkg::res_t      res_o,
  input  logic                  res_ready_i
);

  // one decode step per cycle while the result register is free; steps that
  // move no bits count as steps too
  bitlen_pkg::eng_e    eng_q, eng_d;
  bitlen_pkg::phase_e  phase_q, phase_d;
  bitlen_pkg::status_e fail_st_q, fail_st_d;
  logic [63:0] buf_q, buf_d;
  logic [6:0]  held_q, held_d;
  logic [6:0]  width_q, width_d;
  logic [31:0] base_q, base_d;
  logic [2:0]  dsz_q, dsz_d, rsz_q, rsz_d;
  logic [6:0]  runl_q, runl_d;
  logic [26:0] emit_q, emit_d;
  logic [31:0] nacc_q, nacc_d;
  logic [3:0]  nidx_q, nidx_d;
  logic        ended_q, ended_d;
  logic [5:0]  nres_q, nres_d;
  logic        out_v_q, out_v_d;
  bitlen_pkg::res_t out_q, out_d;

  logic [26:0] eff, rem;
  logic [6:0]  need;
  logic [31:0] x, mask, r, s;
  logic [31:0] nacc_new;
  logic [5:0]  bl;
  logic [7:0]  wsum;
  logic [31:0] hi, lo;
  logic [26:0] n27;
  logic        out_free;

  assign eff = (count_i > bitlen_pkg::MaxCount) ? bitlen_pkg::MaxCount : count_i;
  assign rem = (eff > emit_q) ? eff - emit_q : 27'd0;
  assign out_free = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  always_comb begin
    unique case (phase_q)
      bitlen_pkg::PH_START:  need = 7'd1;
      bitlen_pkg::PH_MIN,
      bitlen_pkg::PH_MAX:    need = 7'd5;
      bitlen_pkg::PH_FIXED:  need = width_q;
      bitlen_pkg::PH_MEAN:   need = 7'd32;
      bitlen_pkg::PH_SIZES:  need = 7'd6;
      bitlen_pkg::PH_DELTA:  need = {4'd0, dsz_q};
      bitlen_pkg::PH_RUNLEN: need = {4'd0, rsz_q};
      bitlen_pkg::PH_RUN:    need = (runl_q != 7'd0) ? width_q : 7'd0;
      default:               need = 7'd0;
    endcase
  end

  assign mask = (need >= 7'd32) ? 32'hFFFF_FFFF : ((32'd1 << need[4:0]) - 32'd1);
  assign x = 32'(buf_q >> (held_q - need)) & mask;

  // nibbles past the eighth are read and dropped
  assign nacc_new = (nidx_q < 4'd8)
                    ? (nacc_q | ({28'd0, x[4:1]} << {nidx_q[2:0], 2'b00})) : nacc_q;
  assign r = nacc_new - base_q;

  always_comb begin
    bl = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (r[i]) bl = 6'(i + 1);
    end
  end

  always_comb begin
    eng_d = eng_q; phase_d = phase_q; buf_d = buf_q; held_d = held_q;
    width_d = width_q; base_d = base_q; dsz_d = dsz_q; rsz_d = rsz_q;
    runl_d = runl_q; emit_d = emit_q; nacc_d = nacc_q; nidx_d = nidx_q;
    ended_d = ended_q; nres_d = nres_q; fail_st_d = fail_st_q;
    out_v_d = out_v_q && !res_ready_i; out_d = out_q;
    req_take_o = 1'b0;
    s = 32'd0; wsum = 8'd0; hi = 32'd0; lo = 32'd0; n27 = 27'd0;

    unique case (eng_q)
      bitlen_pkg::EN_IDLE: begin
        if (req_valid_i) begin
          req_take_o = 1'b1;
          nres_d = 6'd0;
          if (ended_q) begin
            // final word already in; this request only resumes the decode
            eng_d = bitlen_pkg::EN_RUN;
          end else if (phase_q == bitlen_pkg::PH_SKIP) begin
            if (req_i.last) phase_d = bitlen_pkg::PH_START;
          end else if (phase_q == bitlen_pkg::PH_START && rem == 27'd0) begin
            if (!req_i.last) phase_d = bitlen_pkg::PH_SKIP;
          end else begin
            buf_d = {buf_q[31:0], req_i.word};
            held_d = held_q + 7'd32;
            ended_d = req_i.last;
            eng_d = bitlen_pkg::EN_RUN;
          end
        end
      end
      bitlen_pkg::EN_RUN: begin
        if (out_free) begin
          if (rem == 27'd0) begin
            eng_d = bitlen_pkg::EN_IDLE;
            held_d = 7'd0; width_d = 7'd0; runl_d = 7'd0; emit_d = 27'd0;
            nacc_d = 32'd0; nidx_d = 4'd0; buf_d = 64'd0;
            if (ended_q) begin
              phase_d = bitlen_pkg::PH_START; ended_d = 1'b0;
            end else phase_d = bitlen_pkg::PH_SKIP;
          end else if (nres_q == 6'(bitlen_pkg::MaxRes)) begin
            eng_d = bitlen_pkg::EN_IDLE;
          end else if ((phase_q == bitlen_pkg::PH_DELTA && dsz_q == 3'd0 && rsz_q == 3'd0)
                       || held_q < need) begin
            eng_d = ended_q ? bitlen_pkg::EN_FAIL : bitlen_pkg::EN_IDLE;
            fail_st_d = bitlen_pkg::ST_EARLY;
          end else begin
            held_d = held_q - need;
            unique case (phase_q)
              bitlen_pkg::PH_START: begin
                nacc_d = 32'd0; nidx_d = 4'd0;
                phase_d = x[0] ? bitlen_pkg::PH_MEAN : bitlen_pkg::PH_MIN;
              end
              bitlen_pkg::PH_MIN, bitlen_pkg::PH_MAX: begin
                nacc_d = nacc_new;
                if (nidx_q < 4'd8) nidx_d = nidx_q + 4'd1;
                if (!x[0]) begin
                  if (phase_q == bitlen_pkg::PH_MIN) begin
                    base_d = nacc_new; phase_d = bitlen_pkg::PH_MAX;
                  end else if (r == 32'd0 || r[31]) begin
                    emit_d = emit_q + rem;
                    out_v_d = 1'b1; nres_d = nres_q + 6'd1;
                    out_d = '{value: base_q, rep: rem, last: 1'b1,
                              status: bitlen_pkg::ST_OK};
                  end else begin
                    width_d = {1'b0, bl}; phase_d = bitlen_pkg::PH_FIXED;
                  end
                  nacc_d = 32'd0; nidx_d = 4'd0;
                end
              end
              bitlen_pkg::PH_FIXED: begin
                emit_d = emit_q + 27'd1;
                out_v_d = 1'b1; nres_d = nres_q + 6'd1;
                out_d = '{value: x + base_q, rep: 27'd1, last: (rem == 27'd1),
                          status: bitlen_pkg::ST_OK};
              end
              bitlen_pkg::PH_MEAN: begin
                base_d = x; phase_d = bitlen_pkg::PH_SIZES;
              end
              bitlen_pkg::PH_SIZES: begin
                dsz_d = x[5:3]; rsz_d = x[2:0];
                width_d = 7'd0; phase_d = bitlen_pkg::PH_DELTA;
              end
              bitlen_pkg::PH_DELTA: begin
                if (dsz_q == 3'd0) begin
                  phase_d = bitlen_pkg::PH_RUNLEN;
                end else begin
                  s = bitlen_pkg::sext32(x, {3'd0, dsz_q});
                  hi = (32'd1 << (dsz_q - 3'd1)) - 32'd1;
                  lo = ~hi;
                  wsum = {width_q[6], width_q} + s[7:0];
                  if (wsum[7] || wsum > 8'd32) begin
                    eng_d = bitlen_pkg::EN_FAIL;
                    fail_st_d = bitlen_pkg::ST_WIDTH;
                  end else begin
                    width_d = wsum[6:0];
                    if (s != lo && s != hi) phase_d = bitlen_pkg::PH_RUNLEN;
                  end
                end
              end
              bitlen_pkg::PH_RUNLEN: begin
                runl_d = x[6:0]; phase_d = bitlen_pkg::PH_RUN;
              end
              bitlen_pkg::PH_RUN: begin
                if (runl_q == 7'd0) begin
                  phase_d = bitlen_pkg::PH_DELTA;
                end else if (width_q == 7'd0) begin
                  n27 = ({20'd0, runl_q} < rem) ? {20'd0, runl_q} : rem;
                  runl_d = runl_q - n27[6:0];
                  emit_d = emit_q + n27;
                  out_v_d = 1'b1; nres_d = nres_q + 6'd1;
                  out_d = '{value: base_q, rep: n27, last: (n27 == rem),
                            status: bitlen_pkg::ST_OK};
                end else begin
                  runl_d = runl_q - 7'd1;
                  emit_d = emit_q + 27'd1;
                  out_v_d = 1'b1; nres_d = nres_q + 6'd1;
                  out_d = '{value: bitlen_pkg::sext32(x, width_q[5:0]) + base_q,
                            rep: 27'd1, last: (rem == 27'd1), status: bitlen_pkg::ST_OK};
                end
              end
              default: begin
                phase_d = bitlen_pkg::PH_SKIP;
              end
            endcase
          end
        end
      end
      bitlen_pkg::EN_FAIL: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d = '{value: 32'd0, rep: 27'd0, last: 1'b1, status: fail_st_q};
          eng_d = bitlen_pkg::EN_IDLE;
          held_d = 7'd0; width_d = 7'd0; runl_d = 7'd0; emit_d = 27'd0;
          nacc_d = 32'd0; nidx_d = 4'd0; buf_d = 64'd0;
          if (ended_q) begin
            phase_d = bitlen_pkg::PH_START; ended_d = 1'b0;
          end else phase_d = bitlen_pkg::PH_SKIP;
        end
      end
      default: eng_d = bitlen_pkg::EN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q <= bitlen_pkg::EN_IDLE; phase_q <= bitlen_pkg::PH_START;
      buf_q <= 64'd0; held_q <= 7'd0; width_q <= 7'd0; base_q <= 32'd0;
      dsz_q <= 3'd0; rsz_q <= 3'd0; runl_q <= 7'd0; emit_q <= 27'd0;
      nacc_q <= 32'd0; nidx_q <= 4'd0; ended_q <= 1'b0; nres_q <= 6'd0;
      fail_st_q <= bitlen_pkg::ST_OK; out_v_q <= 1'b0;
    end else begin
      eng_q <= eng_d; phase_q <= phase_d; buf_q <= buf_d; held_q <= held_d;
      width_q <= width_d; base_q <= base_d; dsz_q <= dsz_d; rsz_q <= rsz_d;
      runl_q <= runl_d; emit_q <= emit_d; nacc_q <= nacc_d; nidx_q <= nidx_d;
      ended_q <= ended_d; nres_q <= nres_d; fail_st_q <= fail_st_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- design/bitlength_int_stream_decoder.sv -----
// Bit-length integer packet decoder. Codetext words are pushed through a
// two-entry queue; the decode engine takes a word and then runs one decode
// step per cycle while no result waits to be popped: one per field, nibble or
// size read, plus steps that move no bits (a zero-size delta, the end of a
// run, a zero-width run). At most 32 results come from one word; the rest
// wait for the next word, which is dropped when the packet's final word is
// already in.
// Results are (value, repeat) pairs read from a one-entry result register;
// last marks the end of a packet, status flags width errors and early end.
module bitlength_int_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_word_i,
  input  logic        word_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o,
  output logic [26:0] repeat_res_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [26:0] cfg_data_i
);

  logic [26:0] count_q;
  bitlen_pkg::word_req_t fifo_out;
  logic fifo_empty, take, res_v;
  bitlen_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 27'd0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  bitlen_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ('{word: code_word_i, last: word_last_i}),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (fifo_out),
    .empty_o (fifo_empty)
  );

  bitlen_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .req_valid_i (!fifo_empty),
    .req_i       (fifo_out),
    .req_take_o  (take),
    .res_valid_o (res_v),
    .res_o       (res),
    .res_ready_i (pop)
  );

  assign empty        = !res_v;
  assign value_o      = res.value;
  assign repeat_res_o = res.rep;
  assign last_o       = res.last;
  assign status_o     = res.status;

endmodule
